// ----- hdl/smq_pkg.sv -----
// Package for the skill-matched priority queue: sizes, field widths, codes and shared types.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package smq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int FLOW_COUNT  = 32;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int CMD_W       = 2;
  localparam int TAG_W       = 8;
  localparam int PRIO_W      = 8;
  localparam int FLOW_W      = 5;
  localparam int MASK_W      = 32;
  localparam int STATUS_W    = 3;
  localparam int POS_W       = 6;
  localparam int OUT_CNT_W   = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_POP    = 2'd2,
    CMD_MARK   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_FULL     = 3'd1,
    STAT_DUP      = 3'd2,
    STAT_ABSENT   = 3'd3,
    STAT_NO_MATCH = 3'd4
  } status_t;

  // What a cell does at the apply edge.
  typedef enum logic [2:0] {
    ACT_HOLD       = 3'd0,
    ACT_LOAD       = 3'd1,
    ACT_FROM_LEFT  = 3'd2,
    ACT_FROM_RIGHT = 3'd3,
    ACT_SET_READY  = 3'd4
  } action_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
    logic [FLOW_W-1:0] flow;
    logic              ready;
  } entry_t;

  // Fields of a request that every cell compares against.
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
    logic [MASK_W-1:0] mask;
  } req_t;

  // Compare results a cell reports to the control logic.
  typedef struct packed {
    logic tag_hit;
    logic prio_le;
    logic pop_hit;
  } flags_t;

endpackage

`default_nettype wire

// ----- hdl/smq_cell.sv -----
// One queue cell: holds a single entry, compares it with the current request and
// takes its next value from itself, a neighbor or the new entry. Uses smq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smq_cell (
  input  wire logic            clk,
  input  wire logic            cap_en,
  input  wire smq_pkg::req_t   req,
  input  wire logic            occ,
  input  wire smq_pkg::action_t act,
  input  wire smq_pkg::entry_t left_entry,
  input  wire smq_pkg::entry_t right_entry,
  input  wire smq_pkg::entry_t new_entry,
  output smq_pkg::entry_t      entry,
  output smq_pkg::flags_t      flags
);
  import smq_pkg::*;

  entry_t entry_r, entry_nxt;
  flags_t flags_r, flags_nxt;
  logic   served;

  // A flow beyond the configured flow count never matches.
  assign served = (32'(entry_r.flow) < FLOW_COUNT) && req.mask[entry_r.flow];

  always_comb begin
    flags_nxt.tag_hit = occ && (entry_r.tag == req.tag);
    flags_nxt.prio_le = occ && (entry_r.prio <= req.prio);
    flags_nxt.pop_hit = occ && entry_r.ready && served;
  end

  always_comb begin
    entry_nxt = entry_r;
    case (act)
      ACT_LOAD:       entry_nxt = new_entry;
      ACT_FROM_LEFT:  entry_nxt = left_entry;
      ACT_FROM_RIGHT: entry_nxt = right_entry;
      ACT_SET_READY:  entry_nxt.ready = 1'b1;
      default:        entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (cap_en) begin
      flags_r <= flags_nxt;
    end
  end

  assign entry = entry_r;
  assign flags = flags_r;

endmodule

`default_nettype wire

// ----- hdl/smq_scan.sv -----
// Head-first scan over one flag per cell: inclusive prefix OR, first set cell as
// a one-hot vector and as an index, and whether any flag is set. Uses smq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smq_scan (
  input  wire logic [smq_pkg::QUEUE_DEPTH-1:0] hits,
  output logic [smq_pkg::QUEUE_DEPTH-1:0]      prefix,
  output logic [smq_pkg::QUEUE_DEPTH-1:0]      first_hot,
  output logic [smq_pkg::IDX_W-1:0]            first_idx,
  output logic                                 any
);
  import smq_pkg::*;

  logic [QUEUE_DEPTH-1:0] lvl [IDX_W+1];

  // Log-depth prefix OR: each level doubles the reach toward the tail.
  assign lvl[0] = hits;
  for (genvar s = 0; s < IDX_W; s++) begin : g_lvl
    assign lvl[s+1] = lvl[s] | (lvl[s] << (1 << s));
  end

  assign prefix    = lvl[IDX_W];
  assign first_hot = prefix & ~(prefix << 1);
  assign any       = prefix[QUEUE_DEPTH-1];

  always_comb begin
    first_idx = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (first_hot[i]) begin
        first_idx = first_idx | IDX_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/skill_matched_priority_queue_core.sv -----
// The cell compare stage and the apply stage alternate, so a new request is taken only after the last one is applied.
// The result register is loaded by the apply stage, which waits while an earlier result is stalled.
// While a result waits in that register under out_stall, one more request can still be
// accepted, but its apply stage waits until the result leaves; further requests are held off.
// Reset (rst_n low, synchronous) empties the queue and clears all control state at once;
// cell contents are not cleared, since nothing reads a cell beyond the entry count.
`timescale 1ns / 1ps
`default_nettype none

module skill_matched_priority_queue_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [smq_pkg::CMD_W-1:0]      in_command,
  input  wire logic [smq_pkg::TAG_W-1:0]      in_call_tag,
  input  wire logic [smq_pkg::PRIO_W-1:0]     in_call_priority,
  input  wire logic [smq_pkg::FLOW_W-1:0]     in_flow_number,
  input  wire logic                           in_to_head,
  input  wire logic [smq_pkg::MASK_W-1:0]     in_agent_flow_mask,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [smq_pkg::STATUS_W-1:0]        out_status,
  output logic [smq_pkg::POS_W-1:0]           out_position,
  output logic [smq_pkg::TAG_W-1:0]           out_popped_tag,
  output logic [smq_pkg::OUT_CNT_W-1:0]       out_queue_count
);
  import smq_pkg::*;

  // Two-state sequencer: IDLE takes a request while the cells latch their
  // compare flags, APPLY resolves the flags and moves the cells.
  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_APPLY = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  // Request held for the apply stage.
  cmd_t   cmd_r;
  logic   head_r;
  entry_t new_entry_r;

  logic [CNT_W-1:0] count_r, count_nxt;

  // Result register.
  logic                 out_valid_r, out_valid_nxt;
  status_t              status_r, status_nxt;
  logic [POS_W-1:0]     position_r, position_nxt;
  logic [TAG_W-1:0]     popped_r, popped_nxt;
  logic [OUT_CNT_W-1:0] qcount_r, qcount_nxt;

  logic cap_en;
  logic apply_en;
  req_t req;

  entry_t  cell_entry [QUEUE_DEPTH];
  flags_t  cell_flags [QUEUE_DEPTH];
  action_t cell_act   [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] occ;

  logic [QUEUE_DEPTH-1:0] tag_hits, pop_hits, le_rev;
  logic [QUEUE_DEPTH-1:0] tag_pre, pop_pre, pop_hot, le_pre_rev, keep;
  logic [IDX_W-1:0]       le_last_rev;
  logic                   tag_any, pop_any, le_any;

  logic             full;
  logic [CNT_W-1:0] ins_at;
  logic [TAG_W-1:0] popped_sel;
  logic             push_ok;

  // A request is taken only when the sequencer is idle; the output register
  // parts the result side from the input side.
  assign in_stall = (state_r != ST_IDLE);
  assign cap_en   = in_valid && !in_stall;
  assign apply_en = (state_r == ST_APPLY) && !(out_valid_r && out_stall);

  assign req.tag  = in_call_tag;
  assign req.prio = in_call_priority;
  assign req.mask = in_agent_flow_mask;

  // Occupancy of each cell follows from the entry count; it does not change
  // between the compare and the apply edge.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_occ
    assign occ[i] = (CNT_W'(i) < count_r);
  end

  // The row of cells. Each cell sees its neighbors so that a push can shift
  // the tail one place back and a removal can close the gap.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t left_e;
    entry_t right_e;
    if (i == 0) begin : g_first
      assign left_e = cell_entry[i];
    end else begin : g_mid_l
      assign left_e = cell_entry[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_e = cell_entry[i];
    end else begin : g_mid_r
      assign right_e = cell_entry[i+1];
    end

    smq_cell u_cell (
      .clk         (clk),
      .cap_en      (cap_en),
      .req         (req),
      .occ         (occ[i]),
      .act         (cell_act[i]),
      .left_entry  (left_e),
      .right_entry (right_e),
      .new_entry   (new_entry_r),
      .entry       (cell_entry[i]),
      .flags       (cell_flags[i])
    );

    assign tag_hits[i]                 = cell_flags[i].tag_hit;
    assign pop_hits[i]                 = cell_flags[i].pop_hit;
    assign le_rev[QUEUE_DEPTH - 1 - i] = cell_flags[i].prio_le;
    // A cell keeps its entry on a push when some entry at or behind it has
    // a priority number no larger than the new one.
    assign keep[i]                     = le_pre_rev[QUEUE_DEPTH - 1 - i];
  end

  // Tag lookup: tags are unique, so the prefix marks the hit cell and all
  // cells behind it, which is exactly the set that shifts on a removal.
  smq_scan u_tag_scan (
    .hits      (tag_hits),
    .prefix    (tag_pre),
    .first_hot (),
    .first_idx (),
    .any       (tag_any)
  );

  // Pop: the first ready entry whose flow the agent serves.
  smq_scan u_pop_scan (
    .hits      (pop_hits),
    .prefix    (pop_pre),
    .first_hot (pop_hot),
    .first_idx (),
    .any       (pop_any)
  );

  // Insertion point: scanning the priority flags tail-first finds the last
  // entry with a priority number no larger than the pushed one.
  smq_scan u_prio_scan (
    .hits      (le_rev),
    .prefix    (le_pre_rev),
    .first_hot (),
    .first_idx (le_last_rev),
    .any       (le_any)
  );

  assign full = (count_r == CNT_W'(QUEUE_DEPTH));

  // The new entry goes right behind the last such entry, or to the head.
  always_comb begin
    if (head_r || !le_any) begin
      ins_at = '0;
    end else begin
      ins_at = CNT_W'(QUEUE_DEPTH) - CNT_W'(le_last_rev);
    end
  end

  always_comb begin
    popped_sel = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (pop_hot[i]) begin
        popped_sel = popped_sel | cell_entry[i].tag;
      end
    end
  end

  assign push_ok = !tag_any && !full;

  // Per-cell moves for the apply edge.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      cell_act[i] = ACT_HOLD;
      if (apply_en) begin
        case (cmd_r)
          CMD_PUSH: begin
            if (push_ok) begin
              if (head_r) begin
                cell_act[i] = (i == 0) ? ACT_LOAD : ACT_FROM_LEFT;
              end else if (!keep[i]) begin
                if (i == 0) begin
                  cell_act[i] = ACT_LOAD;
                end else if (keep[i-1]) begin
                  cell_act[i] = ACT_LOAD;
                end else begin
                  cell_act[i] = ACT_FROM_LEFT;
                end
              end
            end
          end
          CMD_REMOVE: begin
            if (tag_pre[i]) begin
              cell_act[i] = ACT_FROM_RIGHT;
            end
          end
          CMD_POP: begin
            if (pop_pre[i]) begin
              cell_act[i] = ACT_FROM_RIGHT;
            end
          end
          CMD_MARK: begin
            if (tag_hits[i]) begin
              cell_act[i] = ACT_SET_READY;
            end
          end
          default: cell_act[i] = ACT_HOLD;
        endcase
      end
    end
  end

  // Result and new entry count of the request in the apply stage.
  always_comb begin
    status_nxt   = status_r;
    position_nxt = position_r;
    popped_nxt   = popped_r;
    qcount_nxt   = qcount_r;
    count_nxt    = count_r;
    if (apply_en) begin
      status_nxt   = STAT_OK;
      position_nxt = '0;
      popped_nxt   = '0;
      unique case (cmd_r)
        CMD_PUSH: begin
          // The duplicate check comes before the full check.
          if (tag_any) begin
            status_nxt = STAT_DUP;
          end else if (full) begin
            status_nxt = STAT_FULL;
          end else begin
            position_nxt = POS_W'(ins_at);
            count_nxt    = count_r + CNT_W'(1);
          end
        end
        CMD_REMOVE: begin
          if (tag_any) begin
            count_nxt = count_r - CNT_W'(1);
          end else begin
            status_nxt = STAT_ABSENT;
          end
        end
        CMD_POP: begin
          if (pop_any) begin
            popped_nxt = popped_sel;
            count_nxt  = count_r - CNT_W'(1);
          end else begin
            status_nxt = STAT_NO_MATCH;
          end
        end
        CMD_MARK: begin
          if (!tag_any) begin
            status_nxt = STAT_ABSENT;
          end
        end
        default: status_nxt = STAT_OK;
      endcase
      qcount_nxt = OUT_CNT_W'(count_nxt);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (cap_en) state_nxt = ST_APPLY;
      ST_APPLY: if (apply_en) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (apply_en) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (cap_en) begin
      cmd_r             <= cmd_t'(in_command);
      head_r            <= in_to_head;
      new_entry_r.tag   <= in_call_tag;
      new_entry_r.prio  <= in_call_priority;
      new_entry_r.flow  <= in_flow_number;
      new_entry_r.ready <= 1'b0;
    end
    status_r   <= status_nxt;
    position_r <= position_nxt;
    popped_r   <= popped_nxt;
    qcount_r   <= qcount_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_position    = position_r;
  assign out_popped_tag  = popped_r;
  assign out_queue_count = qcount_r;

endmodule

`default_nettype wire

// ----- hdl/smq_checker.sv -----
// Port-level checks for the skill-matched priority queue, bound to the top level.
// Uses smq_pkg; sees only the ports of skill_matched_priority_queue_core.
`timescale 1ns / 1ps
`default_nettype none

module smq_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_stall,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic [smq_pkg::STATUS_W-1:0]   out_status,
  input wire logic [smq_pkg::POS_W-1:0]      out_position,
  input wire logic [smq_pkg::TAG_W-1:0]      out_popped_tag,
  input wire logic [smq_pkg::OUT_CNT_W-1:0]  out_queue_count
);
  import smq_pkg::*;

  // One request at a time: after an accept the input side is held off.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while another is in flight");

  // The queue never reports more entries than it can hold.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_queue_count) <= QUEUE_DEPTH))
    else $error("queue count beyond depth");

  // A failed request reports neither a position nor a popped tag.
  a_fail_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != STAT_OK)) |-> (out_position == '0 && out_popped_tag == '0))
    else $error("failed request carries payload");

  // A result waiting under stall keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_status) &&
                                  $stable(out_queue_count) && $stable(out_popped_tag)))
    else $error("stalled result changed");

endmodule

bind skill_matched_priority_queue_core smq_checker u_smq_checker (.*);

`default_nettype wire

// ----- tb/tb_skill_matched_priority_queue_core.sv -----
// Self-checking testbench for skill_matched_priority_queue_core: directed and random call requests.
// Predicts each result with its own model of the ordered call queue; depends on smq_pkg and the core.
`timescale 1ns / 1ps

module tb_skill_matched_priority_queue_core;
  import smq_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int QUIET_TAIL    = 60;   // last requests run with no idling on either side
  localparam int HOLD_AT       = 150;  // results seen before the long receiver hold-off
  localparam int HOLD_CYCLES   = 250;
  localparam int DRAIN_CYCLES  = 20;
  localparam int REQ_TARGET    = 550;

  // One call request as the sender presents it.
  typedef struct packed {
    cmd_t              cmd;
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
    logic [FLOW_W-1:0] flow;
    logic              to_head;
    logic [MASK_W-1:0] mask;
  } call_req_t;

  // One result as the queue reports it.
  typedef struct packed {
    status_t              status;
    logic [POS_W-1:0]     pos;
    logic [TAG_W-1:0]     popped;
    logic [OUT_CNT_W-1:0] count;
  } call_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [STATUS_W-1:0]  out_status;
  logic [POS_W-1:0]     out_position;
  logic [TAG_W-1:0]     out_popped_tag;
  logic [OUT_CNT_W-1:0] out_queue_count;

  call_req_t cur_req = '0;

  // Stimulus and scoreboard storage.
  call_req_t    pending_reqs[$];
  call_result_t awaited_results[$];

  // The predicted contents of the call queue, head at index 0.
  entry_t slots[QUEUE_DEPTH];
  int     held = 0;

  // Tags the generator believes to be queued; pops are not tracked, so this is a hint only.
  bit tag_known[256];

  int  total_reqs = 0;
  int  taken_count = 0;
  int  result_count = 0;
  int  error_count = 0;
  int  cycle_count = 0;
  int  send_gap = 0;
  int  stall_left = 0;
  bit  hold_done = 1'b0;
  bit  in_taken = 1'b0;
  logic quiet;

  assign quiet = (taken_count + QUIET_TAIL >= total_reqs);

  always #5 clk = ~clk;

  skill_matched_priority_queue_core i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (cur_req.cmd),
    .in_call_tag        (cur_req.tag),
    .in_call_priority   (cur_req.prio),
    .in_flow_number     (cur_req.flow),
    .in_to_head         (cur_req.to_head),
    .in_agent_flow_mask (cur_req.mask),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_position       (out_position),
    .out_popped_tag     (out_popped_tag),
    .out_queue_count    (out_queue_count)
  );

  // ---------------------------------------------------------------------------
  // Queue prediction
  // ---------------------------------------------------------------------------

  // Index of a queued tag, or -1 when the tag is not held.
  function automatic int locate_tag(logic [TAG_W-1:0] tag);
    int i;
    int hit;
    hit = -1;
    for (i = held - 1; i >= 0; i--) begin
      if (slots[i].tag == tag) begin
        hit = i;
      end
    end
    return hit;
  endfunction

  // Takes one entry out and closes the gap toward the head.
  function automatic void drop_slot(int idx);
    int i;
    for (i = idx; i + 1 < held; i++) begin
      slots[i] = slots[i + 1];
    end
    held--;
  endfunction

  // Applies one accepted request to the predicted queue and returns its result.
  function automatic call_result_t apply_request(call_req_t r);
    call_result_t res;
    int hit;
    int at;
    int i;
    bit found;
    res = '0;
    res.status = STAT_OK;
    found = 1'b0;
    case (r.cmd)
      CMD_PUSH: begin
        // A duplicate tag is reported even when the queue is also full.
        hit = locate_tag(r.tag);
        if (hit >= 0) begin
          res.status = STAT_DUP;
        end else if (held >= QUEUE_DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          // Insert after every entry of equal or smaller priority number, so equal
          // priorities stay first-in first-out; the head flag overrides that.
          at = held;
          if (r.to_head) begin
            at = 0;
          end else begin
            while (at > 0 && slots[at - 1].prio > r.prio) at--;
          end
          for (i = held; i > at; i--) begin
            slots[i] = slots[i - 1];
          end
          slots[at].tag   = r.tag;
          slots[at].prio  = r.prio;
          slots[at].flow  = r.flow;
          slots[at].ready = 1'b0;
          held++;
          res.pos = POS_W'(at);
        end
      end
      CMD_REMOVE: begin
        hit = locate_tag(r.tag);
        if (hit < 0) begin
          res.status = STAT_ABSENT;
        end else begin
          drop_slot(hit);
        end
      end
      CMD_POP: begin
        // The first ready entry from the head whose flow the agent serves.
        res.status = STAT_NO_MATCH;
        for (i = 0; i < held && !found; i++) begin
          if (slots[i].ready && slots[i].flow < FLOW_COUNT && r.mask[slots[i].flow]) begin
            res.popped = slots[i].tag;
            res.status = STAT_OK;
            drop_slot(i);
            found = 1'b1;
          end
        end
      end
      default: begin
        hit = locate_tag(r.tag);
        if (hit < 0) begin
          res.status = STAT_ABSENT;
        end else begin
          slots[hit].ready = 1'b1;
        end
      end
    endcase
    res.count = OUT_CNT_W'(held);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [MASK_W-1:0] pick_mask();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return MASK_W'(1) << $urandom_range(0, MASK_W - 1);
      default: return $urandom;
    endcase
  endfunction

  // Mostly a tag believed to be queued, sometimes any tag at all.
  function automatic logic [TAG_W-1:0] pick_tag();
    logic [TAG_W-1:0] t;
    int tries;
    t = TAG_W'($urandom_range(0, 255));
    for (tries = 0; tries < 12 && !tag_known[t]; tries++) begin
      t = TAG_W'($urandom_range(0, 255));
    end
    return t;
  endfunction

  // A request with every field random; the caller overrides what matters.
  function automatic call_req_t rand_req(cmd_t cmd, logic [TAG_W-1:0] tag);
    call_req_t r;
    r.cmd     = cmd;
    r.tag     = tag;
    r.prio    = $urandom_range(0, 1) ? PRIO_W'($urandom_range(0, 7)) : PRIO_W'($urandom_range(0, 255));
    r.flow    = FLOW_W'($urandom_range(0, 31));
    r.to_head = ($urandom_range(0, 9) == 0);
    r.mask    = pick_mask();
    return r;
  endfunction

  task automatic add_req(call_req_t r);
    if (r.cmd == CMD_PUSH) tag_known[r.tag] = 1'b1;
    if (r.cmd == CMD_REMOVE) tag_known[r.tag] = 1'b0;
    pending_reqs.push_back(r);
  endtask

  task automatic add_push(logic [TAG_W-1:0] tag, logic [PRIO_W-1:0] prio,
                          logic [FLOW_W-1:0] flow, logic head);
    call_req_t r;
    r = rand_req(CMD_PUSH, tag);
    r.prio    = prio;
    r.flow    = flow;
    r.to_head = head;
    add_req(r);
  endtask

  task automatic add_op(cmd_t cmd, logic [TAG_W-1:0] tag, logic [MASK_W-1:0] mask);
    call_req_t r;
    r = rand_req(cmd, tag);
    r.mask = mask;
    add_req(r);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    int i;
    int kind;
    int len;
    int pick;
    call_req_t r;

    // Directed part. The queue starts empty, so the first pop finds nothing and
    // removing or marking any tag reports it absent.
    add_op(CMD_POP, 8'h00, '1);
    add_op(CMD_REMOVE, 8'hA5, '1);
    add_op(CMD_MARK, 8'h5A, '0);
    // Extremes of tag, priority and flow. Tag 8'hFF with priority 0 goes ahead of
    // tag 0, and tag 8'h80 with the same priority as tag 0 lands behind it.
    add_push(8'h00, 8'hFF, 5'd31, 1'b0);
    add_push(8'hFF, 8'h00, 5'd0, 1'b0);
    add_push(8'h80, 8'hFF, 5'd16, 1'b0);
    // A head push reports position zero whatever its priority.
    add_push(8'h40, 8'h80, 5'd0, 1'b1);
    // A tag that is already queued is refused.
    add_push(8'h00, 8'h03, 5'd7, 1'b0);
    // Pushed calls start not ready, so nothing can be popped yet.
    add_op(CMD_POP, 8'h00, '1);
    add_op(CMD_MARK, 8'h00, '0);
    add_op(CMD_MARK, 8'h80, '0);
    // Ready calls whose flows the agent does not serve are skipped.
    add_op(CMD_POP, 8'h00, ~((32'd1 << 31) | (32'd1 << 16)));
    add_op(CMD_POP, 8'h00, 32'd1 << 31);
    add_op(CMD_POP, 8'h00, '1);
    add_op(CMD_REMOVE, 8'hFF, '0);
    add_op(CMD_REMOVE, 8'hFF, '0);
    add_op(CMD_MARK, 8'h40, '0);
    add_op(CMD_POP, 8'h00, 32'h0000_0001);
    add_op(CMD_POP, 8'h00, 32'h0000_0001);

    // Fill to the brim with distinct tags, then push on into the full queue; a
    // queued tag pushed then still reports a duplicate.
    for (i = 1; i <= QUEUE_DEPTH + 6; i++) begin
      r = rand_req(CMD_PUSH, TAG_W'(i));
      add_req(r);
    end
    add_push(8'h01, 8'h00, 5'd0, 1'b0);

    // Random phases: filling, churning and draining, each with random content.
    while (pending_reqs.size() < REQ_TARGET) begin
      kind = $urandom_range(0, 2);
      len  = $urandom_range(25, 60);
      for (i = 0; i < len; i++) begin
        pick = $urandom_range(0, 99);
        case (kind)
          0: pick = (pick < 70) ? 0 : (pick < 85) ? 3 : (pick < 95) ? 2 : 1;
          1: pick = (pick < 30) ? 0 : (pick < 60) ? 3 : (pick < 85) ? 2 : 1;
          default: pick = (pick < 10) ? 0 : (pick < 50) ? 3 : (pick < 90) ? 2 : 1;
        endcase
        case (pick)
          0: r = rand_req(CMD_PUSH, ($urandom_range(0, 9) == 0) ? pick_tag()
                                                                : TAG_W'($urandom_range(0, 255)));
          1: r = rand_req(CMD_REMOVE, pick_tag());
          2: r = rand_req(CMD_POP, TAG_W'($urandom_range(0, 255)));
          default: r = rand_req(CMD_MARK, pick_tag());
        endcase
        add_req(r);
      end
    end
    total_reqs = pending_reqs.size();

    // Reset is held low from the start and released on a falling edge.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for every request to go in and every result to come back, then let the
    // core run on idle in case anything unexpected follows.
    while (pending_reqs.size() != 0 || in_valid || awaited_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && awaited_results.size() == 0) begin
      $display("tb_skill_matched_priority_queue_core: done, clean");
    end else begin
      $display("tb_skill_matched_priority_queue_core: done, errors");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: presents requests on the falling edge, with random gaps.
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (rst_n) begin
      // A request not yet taken stays on the port unchanged.
      if (!in_valid || in_taken) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          cur_req  <= pending_reqs.pop_front();
          in_valid <= 1'b1;
          // The gap, if any, starts once this request has been taken.
          if (!quiet && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 10);
        end else begin
          in_valid <= 1'b0;
        end
      end
      in_taken = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall: random bursts, plus one long hold-off that backs the core up
  // into its input while the driver keeps offering requests.
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (rst_n) begin
      if (!hold_done && result_count >= HOLD_AT) begin
        hold_done = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (!quiet && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 10);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: on each rising edge, predicts accepted requests and checks results.
  // ---------------------------------------------------------------------------

  task automatic check_field(string name, int expd, int got);
    if (expd != got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expd, got);
    end
  endtask

  always @(posedge clk) begin
    call_result_t want;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("tb_skill_matched_priority_queue_core: done, errors");
      $finish;
    end else if (rst_n) begin
      // A result leaves the core no earlier than the edge after its request, so
      // its expectation is always already queued here.
      if (out_valid && !out_stall) begin
        result_count++;
        if (awaited_results.size() == 0) begin
          error_count++;
          $display("%0t: result with nothing outstanding, expected none, actual status %0d",
                   $time, out_status);
        end else begin
          want = awaited_results.pop_front();
          check_field("status", want.status, out_status);
          check_field("position", want.pos, out_position);
          check_field("popped_tag", want.popped, out_popped_tag);
          check_field("queue_count", want.count, out_queue_count);
        end
      end
      if (in_valid && !in_stall) begin
        awaited_results.push_back(apply_request(cur_req));
        taken_count++;
        in_taken = 1'b1;
      end
    end
  end

endmodule
